>>> src/ipcidr_pkg.sv
// Shared types, constants and helpers for the IPv4 CIDR text parser.
package ipcidr_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [9:0] OCTET_MAX   = 10'd255;
    localparam logic [6:0] PREFIX_FULL = 7'd32;
    localparam logic [1:0] LAST_OCTET  = 2'd3;
    localparam logic [1:0] MAX_DIGITS  = 2'd3;
    localparam logic [1:0] MAX_PFX_DIG = 2'd2;
    localparam logic [1:0] PFX_SAT     = 2'd3;

    // bit positions in allow_flags
    localparam int ALLOW_DIGIT = 0;
    localparam int ALLOW_DOT   = 1;
    localparam int ALLOW_SLASH = 2;

    localparam logic [2:0] ALLOW_RESET = 3'b001;

    typedef struct packed {
        logic [9:0]  octet_accum;
        logic [23:0] done_octets;
        logic [1:0]  octet_index;
        logic [1:0]  digit_count;
        logic [2:0]  allow_flags;
        logic [1:0]  after_slash_count;
        logic        in_prefix;
        logic [6:0]  prefix_value;
        logic        error_seen;
    } t_parse_state;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
        logic [31:0] prefix_mask;
        logic [5:0]  prefix_length;
    } t_result;

    localparam t_parse_state PARSE_RESET = '{
        octet_accum:       10'd0,
        done_octets:       24'd0,
        octet_index:       2'd0,
        digit_count:       2'd0,
        allow_flags:       ALLOW_RESET,
        after_slash_count: 2'd0,
        in_prefix:         1'b0,
        prefix_value:      7'd0,
        error_seen:        1'b0
    };

    // len leading ones from bit 31; len is at most 32
    function automatic logic [31:0] prefix_to_mask(input logic [5:0] len);
        logic [31:0] ones;
        ones = 32'hFFFF_FFFF;
        prefix_to_mask = ~(ones >> len);
    endfunction

endpackage

>>> src/ipcidr_step.sv
// Per-character parse step: next parser state and the result for a final character.
module ipcidr_step
    import ipcidr_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_char_code,
    input  logic         i_last_char,
    output t_parse_state o_next_state,
    output t_result      o_result
);

    logic         is_digit;
    logic [3:0]   digit;
    logic [1:0]   dc_inc;
    t_parse_state upd;
    logic [6:0]   len;
    logic         ok;

    assign is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign digit    = i_char_code[3:0];
    assign dc_inc   = i_state.digit_count + 2'd1;

    always_comb begin
        upd = i_state;
        if (!i_state.error_seen) begin
            priority if (i_state.in_prefix) begin
                priority if (!is_digit) begin
                    upd.error_seen = 1'b1;
                end else if (i_state.after_slash_count >= MAX_PFX_DIG) begin
                    upd.error_seen        = 1'b1;
                    upd.after_slash_count = PFX_SAT;
                end else begin
                    upd.prefix_value      = 7'(i_state.prefix_value * 7'd10 + 7'(digit));
                    upd.after_slash_count = i_state.after_slash_count + 2'd1;
                end
            end else if (is_digit) begin
                if (!i_state.allow_flags[ALLOW_DIGIT]) begin
                    upd.error_seen = 1'b1;
                end else begin
                    upd.octet_accum = 10'(i_state.octet_accum * 10'd10 + 10'(digit));
                    upd.digit_count = dc_inc;
                    if (dc_inc == MAX_DIGITS) begin
                        upd.allow_flags[ALLOW_DIGIT] = 1'b0;
                    end
                    if (i_state.octet_index != LAST_OCTET) begin
                        upd.allow_flags[ALLOW_DOT] = 1'b1;
                    end else begin
                        upd.allow_flags[ALLOW_DOT]   = 1'b0;
                        upd.allow_flags[ALLOW_SLASH] = 1'b1;
                    end
                end
            end else if (i_char_code == CHAR_DOT) begin
                priority if (!i_state.allow_flags[ALLOW_DOT] || i_last_char) begin
                    upd.error_seen = 1'b1;
                end else if (i_state.octet_accum > OCTET_MAX) begin
                    upd.error_seen = 1'b1;
                end else begin
                    upd.done_octets = {i_state.done_octets[15:0], i_state.octet_accum[7:0]};
                    upd.octet_index = i_state.octet_index + 2'd1;
                    upd.octet_accum = 10'd0;
                    upd.digit_count = 2'd0;
                    upd.allow_flags = ALLOW_RESET;
                end
            end else if (i_char_code == CHAR_SLASH) begin
                if (!i_state.allow_flags[ALLOW_SLASH] || i_last_char) begin
                    upd.error_seen = 1'b1;
                end else begin
                    upd.in_prefix = 1'b1;
                end
            end else begin
                upd.error_seen = 1'b1;
            end
        end
    end

    // judge the finished string on the updated state
    assign len = upd.in_prefix ? upd.prefix_value : PREFIX_FULL;
    assign ok  = !upd.error_seen && (upd.octet_index == LAST_OCTET) &&
                 (upd.octet_accum <= OCTET_MAX) && (len <= PREFIX_FULL);

    always_comb begin
        if (ok) begin
            o_result.valid_res     = 1'b1;
            o_result.address       = {upd.done_octets, upd.octet_accum[7:0]};
            o_result.prefix_length = len[5:0];
            o_result.prefix_mask   = prefix_to_mask(len[5:0]);
        end else begin
            o_result = '0;
        end
    end

    // clear for the next string after the final character
    assign o_next_state = i_last_char ? PARSE_RESET : upd;

endmodule

>>> src/ipv4_cidr_text_parser.sv
// Top level of the IPv4 CIDR text parser: input register, parse state and result register.
//
// Feed one ASCII character per transfer with i_last_char set on the final one;
// a new character can be taken every cycle. The block registers the character,
// runs one parse step on it against the stored state, and for a final character
// loads one result into the output register as that character leaves the input
// register. Non-final characters yield nothing. While a result waits
// on i_out_stall, characters that are not final keep flowing; a final character
// holds in the input register until the output register frees. After each final
// character the parser is back in its reset state.
module ipv4_cidr_text_parser
    import ipcidr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_valid_res,
    output logic [31:0] o_address,
    output logic [31:0] o_prefix_mask,
    output logic [5:0]  o_prefix_length
);

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    t_result      r_out;
    t_result      n_out;
    logic         adv;
    logic         in_take;

    ipcidr_step u_step (
        .i_state      (r_state),
        .i_char_code  (r_in_char),
        .i_last_char  (r_in_last),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    // advance the held character unless it is final and the result slot is blocked
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_valid_res     = r_out.valid_res;
    assign o_address       = r_out.address;
    assign o_prefix_mask   = r_out.prefix_mask;
    assign o_prefix_length = r_out.prefix_length;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_state == PARSE_RESET)
        else $error("parser state not cleared after final character");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.valid_res |->
            r_out.address == 32'd0 && r_out.prefix_mask == 32'd0 &&
            r_out.prefix_length == 6'd0)
        else $error("invalid result carries nonzero fields");

    a_mask_matches_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.valid_res |->
            r_out.prefix_length <= 6'd32 &&
            $countones(r_out.prefix_mask) == int'(r_out.prefix_length))
        else $error("prefix mask disagrees with prefix length");

    a_final_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && r_in_last && $stable(r_in_char))
        else $error("blocked final character lost");

endmodule

>>> tb/ipv4_cidr_text_parser_tb.sv
// Self-checking testbench for the IPv4 CIDR text parser with a built-in parse predictor.
module ipv4_cidr_text_parser_tb
    import ipcidr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } t_char_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_last_char = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_valid_res;
    logic [31:0] o_address;
    logic [31:0] o_prefix_mask;
    logic [5:0]  o_prefix_length;

    t_char_item  text_chars[$];
    t_result     pending_results[$];
    logic [7:0]  text_buf[$];
    logic        in_took = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          phase_chars = 0;
    int          n_errors = 0;

    // parser state as the predictor tracks it
    logic [9:0]  cur_octet;
    logic [23:0] prev_octets;
    logic [1:0]  oct_idx;
    logic [1:0]  n_digits;
    logic        may_digit;
    logic        may_dot;
    logic        may_slash;
    logic [1:0]  n_pfx_digits;
    logic        seen_slash;
    logic [6:0]  pfx_val;
    logic        bad;

    ipv4_cidr_text_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_code     (i_char_code),
        .i_last_char     (i_last_char),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_valid_res     (o_valid_res),
        .o_address       (o_address),
        .o_prefix_mask   (o_prefix_mask),
        .o_prefix_length (o_prefix_length)
    );

    always #5 i_clk = ~i_clk;

    task automatic clear_parser();
        cur_octet    = 10'd0;
        prev_octets  = 24'd0;
        oct_idx      = 2'd0;
        n_digits     = 2'd0;
        may_digit    = 1'b1;
        may_dot      = 1'b0;
        may_slash    = 1'b0;
        n_pfx_digits = 2'd0;
        seen_slash   = 1'b0;
        pfx_val      = 7'd0;
        bad          = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic fin);
        logic       is_digit;
        logic [3:0] d;
        logic       ok;
        logic [6:0] len;
        t_result    r;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d = 4'(c - CHAR_ZERO);
        if (!bad) begin
            if (seen_slash) begin
                if (!is_digit) begin
                    bad = 1'b1;
                end else if (n_pfx_digits >= MAX_PFX_DIG) begin
                    bad = 1'b1;
                    n_pfx_digits = PFX_SAT;
                end else begin
                    pfx_val = pfx_val * 7'd10 + 7'(d);
                    n_pfx_digits = n_pfx_digits + 2'd1;
                end
            end else if (is_digit) begin
                if (!may_digit) begin
                    bad = 1'b1;
                end else begin
                    cur_octet = cur_octet * 10'd10 + 10'(d);
                    n_digits = n_digits + 2'd1;
                    if (n_digits >= MAX_DIGITS)
                        may_digit = 1'b0;
                    if (oct_idx < LAST_OCTET) begin
                        may_dot = 1'b1;
                    end else begin
                        may_dot = 1'b0;
                        may_slash = 1'b1;
                    end
                end
            end else if (c == CHAR_DOT) begin
                if (!may_dot || fin || cur_octet > OCTET_MAX) begin
                    bad = 1'b1;
                end else begin
                    prev_octets = {prev_octets[15:0], cur_octet[7:0]};
                    oct_idx = oct_idx + 2'd1;
                    cur_octet = 10'd0;
                    n_digits = 2'd0;
                    may_digit = 1'b1;
                    may_dot = 1'b0;
                    may_slash = 1'b0;
                end
            end else if (c == CHAR_SLASH) begin
                if (!may_slash || fin)
                    bad = 1'b1;
                else
                    seen_slash = 1'b1;
            end else begin
                bad = 1'b1;
            end
        end
        if (fin) begin
            ok = !bad && oct_idx == LAST_OCTET && cur_octet <= OCTET_MAX;
            len = seen_slash ? pfx_val : PREFIX_FULL;
            if (len > PREFIX_FULL)
                ok = 1'b0;
            r = '0;
            if (ok) begin
                r.valid_res = 1'b1;
                r.address = {prev_octets, cur_octet[7:0]};
                r.prefix_mask = (len == 7'd0) ? 32'd0 : (32'hFFFF_FFFF << (7'd32 - len));
                r.prefix_length = len[5:0];
            end
            pending_results.push_back(r);
            clear_parser();
        end
    endtask

    // Move the text buffer into the transfer queue, final flag on its last char.
    task automatic emit_line();
        t_char_item it;
        for (int i = 0; i < text_buf.size(); i++) begin
            it.ch = text_buf[i];
            it.fin = (i == text_buf.size() - 1);
            text_chars.push_back(it);
        end
        phase_chars += text_buf.size();
        text_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        emit_line();
    endtask

    task automatic append_number(input int value, input int width);
        int nd;
        int div;
        nd = (value >= 100) ? 3 : (value >= 10) ? 2 : 1;
        if (width > nd)
            nd = width;
        div = 1;
        repeat (nd - 1) div = div * 10;
        while (div > 0) begin
            text_buf.push_back(8'(CHAR_ZERO + (value / div) % 10));
            div = div / 10;
        end
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(3))
            0: pick_char = 8'(CHAR_ZERO + $urandom_range(9));
            1: pick_char = CHAR_DOT;
            2: pick_char = CHAR_SLASH;
            default: pick_char = 8'($urandom_range(255));
        endcase
    endfunction

    task automatic gen_random_line();
        int v;
        int w;
        int pos;
        if ($urandom_range(99) < 70) begin
            for (int k = 0; k < 4; k++) begin
                if (k > 0)
                    text_buf.push_back(CHAR_DOT);
                case ($urandom_range(39))
                    0: v = 0;
                    1: v = 255;
                    2: v = 256 + $urandom_range(743);
                    3, 4, 5, 6, 7, 8: v = $urandom_range(9);
                    default: v = $urandom_range(255);
                endcase
                w = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 1;
                append_number(v, w);
            end
            if ($urandom_range(9) < 6) begin
                text_buf.push_back(CHAR_SLASH);
                case ($urandom_range(19))
                    0: v = 0;
                    1: v = 32;
                    2: v = 33 + $urandom_range(66);
                    default: v = $urandom_range(32);
                endcase
                w = ($urandom_range(9) == 0) ? 3 : ($urandom_range(3) == 0) ? 2 : 1;
                append_number(v, w);
            end
            // break about one in four well-formed strings
            if ($urandom_range(3) == 0) begin
                pos = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(5))
                    0: text_buf[pos] = 8'($urandom_range(255));
                    1: text_buf.delete(pos);
                    2: text_buf.insert(pos, pick_char());
                    3: text_buf = text_buf[0:pos];
                    4: text_buf.push_back($urandom_range(1) ? CHAR_DOT : CHAR_SLASH);
                    default: text_buf.insert(pos, 8'(CHAR_ZERO + $urandom_range(9)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 12)) text_buf.push_back(pick_char());
        end
        emit_line();
    endtask

    task automatic wait_drained();
        while (text_chars.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin : drive
        t_char_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_took) begin
                if (text_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = text_chars.pop_front();
                    i_in_valid <= 1'b1;
                    i_char_code <= nxt.ch;
                    i_last_char <= nxt.fin;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin : watch
        t_result exp_r;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                parse_char(i_char_code, i_last_char);
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: address %h", o_address);
                    n_errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_valid_res !== exp_r.valid_res) begin
                        $error("valid_res: expected %0d, got %0d", exp_r.valid_res, o_valid_res);
                        n_errors++;
                    end
                    if (o_address !== exp_r.address) begin
                        $error("address: expected %h, got %h", exp_r.address, o_address);
                        n_errors++;
                    end
                    if (o_prefix_mask !== exp_r.prefix_mask) begin
                        $error("prefix_mask: expected %h, got %h",
                               exp_r.prefix_mask, o_prefix_mask);
                        n_errors++;
                    end
                    if (o_prefix_length !== exp_r.prefix_length) begin
                        $error("prefix_length: expected %0d, got %0d",
                               exp_r.prefix_length, o_prefix_length);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 61, 0, 25};
        stall_tab = '{0, 0, 61, 25};
        clear_parser();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_text("255.255.255.255/32");
        push_text("0.0.0.0/0");
        push_text("1.2.3.4");
        push_text("009.010.100.001/08");
        push_text("256.1.1.1");
        push_text("1.2.3.1234");
        push_text("1.2.3.4/33");
        push_text("1.2.3.4/123");
        push_text("1.2.3.");
        push_text("1.2.3.4/");
        push_text("1.2.3");
        push_text("7");
        push_text("1.a.3.4");
        push_text("1.2.3.4/3x");
        push_text("1.2/3.4");
        push_text("..");
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            phase_chars = 0;
            while (phase_chars < 425)
                gen_random_line();
            // hold off new strings until every result is back
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
src/ipcidr_pkg.sv
src/ipcidr_step.sv
src/ipv4_cidr_text_parser.sv
tb/ipv4_cidr_text_parser_tb.sv
